[rtl/core/urxf_pkg.sv]
// Shared constants and codes for the UART receive FIFO with loss markers.
package urxf_pkg;

    localparam int DEFAULT_DEPTH = 256;

    // One stored entry: byte in bits 7:0, flags in bits 13:8.
    localparam int BYTE_W  = 8;
    localparam int FLAGS_W = 6;
    localparam int ENTRY_W = BYTE_W + FLAGS_W;

    localparam int CMD_W    = 2;
    localparam int WORD_W   = 12;
    localparam int STATUS_W = 2;
    localparam int OCC_OUT_W = 9;
    localparam int CNT_W    = 32;

    localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MARK    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DISCARD = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;

    // Bit positions inside the received UART word.
    localparam int WB_FRAMING = 8;
    localparam int WB_PARITY  = 9;
    localparam int WB_BREAK   = 10;
    localparam int WB_OVERRUN = 11;

    // Bit positions inside the entry flags.
    localparam int FB_LOSS  = 4;
    localparam int FB_EPOCH = 5;

    // Statistic counter slots.
    localparam int CNT_EPISODES = 0;
    localparam int CNT_DROPPED  = 1;
    localparam int CNT_OBSERVED = 2;
    localparam int CNT_OVERRUN  = 3;
    localparam int CNT_FRAMING  = 4;
    localparam int CNT_PARITY   = 5;
    localparam int CNT_BREAK    = 6;
    localparam int CNT_NUM      = 7;

endpackage

[rtl/core/uart_rx_fifo_with_loss_markers.sv]
// Top level of the UART receive FIFO with loss and epoch markers.
// The block takes one command per transfer (push, pop, mark epoch, discard all) and returns
// exactly one result per command. It accepts one command every cycle as long as results are
// taken. Each command's result goes through a middle stage, which covers the synchronous
// read of the entry memory that a pop needs, and then the output register. A stalled output
// holds the result and stalls the input once the single internal stage behind it is also
// full. Entries live in a FIFO_DEPTH deep memory that needs no clearing after reset.
// Pointers, pending marks, the high-water mark and the wrapping 32-bit statistics sit in
// flip-flops.
module uart_rx_fifo_with_loss_markers #(
    parameter int FIFO_DEPTH = urxf_pkg::DEFAULT_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [urxf_pkg::CMD_W-1:0]       command,
    input  logic [urxf_pkg::WORD_W-1:0]      uart_word,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [urxf_pkg::STATUS_W-1:0]    status,
    output logic [urxf_pkg::BYTE_W-1:0]      data_byte,
    output logic [urxf_pkg::FLAGS_W-1:0]     entry_flags,
    output logic [urxf_pkg::OCC_OUT_W-1:0]   occupancy_before,
    output logic [urxf_pkg::OCC_OUT_W-1:0]   high_water,
    output logic [urxf_pkg::CNT_W-1:0]       overflow_episodes,
    output logic [urxf_pkg::CNT_W-1:0]       dropped_count,
    output logic [urxf_pkg::CNT_W-1:0]       observed_count,
    output logic [urxf_pkg::CNT_W-1:0]       overrun_count,
    output logic [urxf_pkg::CNT_W-1:0]       framing_count,
    output logic [urxf_pkg::CNT_W-1:0]       parity_count,
    output logic [urxf_pkg::CNT_W-1:0]       break_count
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int OW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(FIFO_DEPTH - 1);
    localparam logic [OW-1:0] DEPTH_OCC = OW'(FIFO_DEPTH);

    // Pointer state: an address plus a wrap bit, together counting modulo 2 * FIFO_DEPTH.
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic          wr_wrap_reg, wr_wrap_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic          rd_wrap_reg, rd_wrap_next;
    logic          loss_reg, loss_next;
    logic          epoch_reg, epoch_next;
    logic          run_reg, run_next;
    logic [OW-1:0] peak_reg, peak_next;
    logic [urxf_pkg::CNT_W-1:0] cnt_reg  [urxf_pkg::CNT_NUM];
    logic [urxf_pkg::CNT_W-1:0] cnt_next [urxf_pkg::CNT_NUM];

    // Middle stage: waits for the memory read data.
    logic                          s1_valid_reg, s1_valid_next;
    logic [urxf_pkg::STATUS_W-1:0] s1_status_reg, s1_status_next;
    logic                          s1_pop_reg, s1_pop_next;
    logic [OW-1:0]                 s1_occ_reg, s1_occ_next;

    logic out_valid_reg, out_valid_next;
    logic [urxf_pkg::STATUS_W-1:0]  out_status_reg;
    logic [urxf_pkg::BYTE_W-1:0]    out_byte_reg;
    logic [urxf_pkg::FLAGS_W-1:0]   out_flags_reg;
    logic [urxf_pkg::OCC_OUT_W-1:0] out_occ_reg;
    logic [urxf_pkg::OCC_OUT_W-1:0] out_hw_reg;
    logic [urxf_pkg::CNT_W-1:0]     out_cnt_reg [urxf_pkg::CNT_NUM];

    logic                          accept;
    logic                          advance;
    logic [OW-1:0]                 occ;
    logic                          ram_wr_en;
    logic [urxf_pkg::ENTRY_W-1:0]  ram_wr_data;
    logic                          ram_rd_en;
    logic [urxf_pkg::ENTRY_W-1:0]  ram_rd_data;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (wr_wrap_reg == rd_wrap_reg)
        begin
            occ = OW'(wr_addr_reg) - OW'(rd_addr_reg);
        end
        else
        begin
            occ = DEPTH_OCC - OW'(rd_addr_reg) + OW'(wr_addr_reg);
        end
    end

    always_comb
    begin
        wr_addr_next   = wr_addr_reg;
        wr_wrap_next   = wr_wrap_reg;
        rd_addr_next   = rd_addr_reg;
        rd_wrap_next   = rd_wrap_reg;
        loss_next      = loss_reg;
        epoch_next     = epoch_reg;
        run_next       = run_reg;
        peak_next      = peak_reg;
        cnt_next       = cnt_reg;
        s1_status_next = s1_status_reg;
        s1_pop_next    = s1_pop_reg;
        s1_occ_next    = s1_occ_reg;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        ram_wr_data    = {2'b00, uart_word[urxf_pkg::WB_OVERRUN:urxf_pkg::WB_FRAMING],
                          uart_word[urxf_pkg::BYTE_W-1:0]};
        ram_wr_data[urxf_pkg::BYTE_W + urxf_pkg::FB_LOSS]  = loss_reg;
        ram_wr_data[urxf_pkg::BYTE_W + urxf_pkg::FB_EPOCH] = epoch_reg;

        if (accept)
        begin
            s1_status_next = urxf_pkg::ST_DONE;
            s1_pop_next    = 1'b0;
            s1_occ_next    = occ;
            case (command)
                urxf_pkg::CMD_PUSH:
                begin
                    cnt_next[urxf_pkg::CNT_OBSERVED] = cnt_reg[urxf_pkg::CNT_OBSERVED] + 1'b1;
                    if (uart_word[urxf_pkg::WB_OVERRUN])
                    begin
                        cnt_next[urxf_pkg::CNT_OVERRUN] = cnt_reg[urxf_pkg::CNT_OVERRUN] + 1'b1;
                    end
                    if (uart_word[urxf_pkg::WB_FRAMING])
                    begin
                        cnt_next[urxf_pkg::CNT_FRAMING] = cnt_reg[urxf_pkg::CNT_FRAMING] + 1'b1;
                    end
                    if (uart_word[urxf_pkg::WB_PARITY])
                    begin
                        cnt_next[urxf_pkg::CNT_PARITY] = cnt_reg[urxf_pkg::CNT_PARITY] + 1'b1;
                    end
                    if (uart_word[urxf_pkg::WB_BREAK])
                    begin
                        cnt_next[urxf_pkg::CNT_BREAK] = cnt_reg[urxf_pkg::CNT_BREAK] + 1'b1;
                    end
                    if (occ == DEPTH_OCC)
                    begin
                        // An episode is counted only on the first drop of a run.
                        cnt_next[urxf_pkg::CNT_DROPPED] = cnt_reg[urxf_pkg::CNT_DROPPED] + 1'b1;
                        loss_next = 1'b1;
                        if (!run_reg)
                        begin
                            cnt_next[urxf_pkg::CNT_EPISODES] =
                                cnt_reg[urxf_pkg::CNT_EPISODES] + 1'b1;
                            run_next = 1'b1;
                        end
                        s1_status_next = urxf_pkg::ST_DROPPED;
                    end
                    else
                    begin
                        ram_wr_en  = 1'b1;
                        loss_next  = 1'b0;
                        epoch_next = 1'b0;
                        run_next   = 1'b0;
                        if (wr_addr_reg == LAST_ADDR)
                        begin
                            wr_addr_next = '0;
                            wr_wrap_next = !wr_wrap_reg;
                        end
                        else
                        begin
                            wr_addr_next = wr_addr_reg + 1'b1;
                        end
                    end
                end
                urxf_pkg::CMD_POP:
                begin
                    if (occ == '0)
                    begin
                        s1_status_next = urxf_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        s1_pop_next = 1'b1;
                        if (occ > peak_reg)
                        begin
                            peak_next = occ;
                        end
                        if (rd_addr_reg == LAST_ADDR)
                        begin
                            rd_addr_next = '0;
                            rd_wrap_next = !rd_wrap_reg;
                        end
                        else
                        begin
                            rd_addr_next = rd_addr_reg + 1'b1;
                        end
                    end
                end
                urxf_pkg::CMD_MARK:
                begin
                    epoch_next = 1'b1;
                end
                default:
                begin
                    if (occ > peak_reg)
                    begin
                        peak_next = occ;
                    end
                    rd_addr_next = wr_addr_reg;
                    rd_wrap_next = wr_wrap_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else
        begin
            s1_valid_next = s1_valid_reg && !advance;
        end
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    urxf_entry_ram #(
        .DEPTH (FIFO_DEPTH),
        .AW    (AW)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_addr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_addr_reg   <= '0;
            wr_wrap_reg   <= 1'b0;
            rd_addr_reg   <= '0;
            rd_wrap_reg   <= 1'b0;
            loss_reg      <= 1'b0;
            epoch_reg     <= 1'b0;
            run_reg       <= 1'b0;
            peak_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < urxf_pkg::CNT_NUM; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            wr_addr_reg   <= wr_addr_next;
            wr_wrap_reg   <= wr_wrap_next;
            rd_addr_reg   <= rd_addr_next;
            rd_wrap_reg   <= rd_wrap_next;
            loss_reg      <= loss_next;
            epoch_reg     <= epoch_next;
            run_reg       <= run_next;
            peak_reg      <= peak_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_status_reg <= s1_status_next;
        s1_pop_reg    <= s1_pop_next;
        s1_occ_reg    <= s1_occ_next;
    end

    // When the middle stage moves on, the live counters and peak still reflect exactly
    // the commands up to and including that stage's one: a command accepted at the same
    // edge only updates them at that edge.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= s1_status_reg;
            out_occ_reg    <= urxf_pkg::OCC_OUT_W'(s1_occ_reg);
            out_hw_reg     <= urxf_pkg::OCC_OUT_W'(peak_reg);
            out_cnt_reg    <= cnt_reg;
            if (s1_pop_reg)
            begin
                out_byte_reg  <= ram_rd_data[urxf_pkg::BYTE_W-1:0];
                out_flags_reg <= ram_rd_data[urxf_pkg::ENTRY_W-1:urxf_pkg::BYTE_W];
            end
            else
            begin
                out_byte_reg  <= '0;
                out_flags_reg <= '0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = out_status_reg;
    assign data_byte         = out_byte_reg;
    assign entry_flags       = out_flags_reg;
    assign occupancy_before  = out_occ_reg;
    assign high_water        = out_hw_reg;
    assign overflow_episodes = out_cnt_reg[urxf_pkg::CNT_EPISODES];
    assign dropped_count     = out_cnt_reg[urxf_pkg::CNT_DROPPED];
    assign observed_count    = out_cnt_reg[urxf_pkg::CNT_OBSERVED];
    assign overrun_count     = out_cnt_reg[urxf_pkg::CNT_OVERRUN];
    assign framing_count     = out_cnt_reg[urxf_pkg::CNT_FRAMING];
    assign parity_count      = out_cnt_reg[urxf_pkg::CNT_PARITY];
    assign break_count       = out_cnt_reg[urxf_pkg::CNT_BREAK];

endmodule

[rtl/core/urxf_entry_ram.sv]
// Entry memory: one write port, one read port with registered read data.
module urxf_entry_ram #(
    parameter int DEPTH = urxf_pkg::DEFAULT_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [urxf_pkg::ENTRY_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [urxf_pkg::ENTRY_W-1:0] rd_data
);

    logic [urxf_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [urxf_pkg::ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read data holds until the next read, so a stalled consumer keeps it.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[test/urxf_result_checker.sv]
`timescale 1ns / 100ps
// Result checker for the UART receive FIFO: predicts every command's result and compares it.
module urxf_result_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [urxf_pkg::CMD_W-1:0]       command,
    input  logic [urxf_pkg::WORD_W-1:0]      uart_word,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [urxf_pkg::STATUS_W-1:0]    status,
    input  logic [urxf_pkg::BYTE_W-1:0]      data_byte,
    input  logic [urxf_pkg::FLAGS_W-1:0]     entry_flags,
    input  logic [urxf_pkg::OCC_OUT_W-1:0]   occupancy_before,
    input  logic [urxf_pkg::OCC_OUT_W-1:0]   high_water,
    input  logic [urxf_pkg::CNT_W-1:0]       overflow_episodes,
    input  logic [urxf_pkg::CNT_W-1:0]       dropped_count,
    input  logic [urxf_pkg::CNT_W-1:0]       observed_count,
    input  logic [urxf_pkg::CNT_W-1:0]       overrun_count,
    input  logic [urxf_pkg::CNT_W-1:0]       framing_count,
    input  logic [urxf_pkg::CNT_W-1:0]       parity_count,
    input  logic [urxf_pkg::CNT_W-1:0]       break_count,
    output int                               fail_count,
    output int                               pending_results
);
    import urxf_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH;
    localparam int PTR_W = $clog2(DEPTH) + 1;

    typedef struct {
        logic [STATUS_W-1:0]              status;
        logic [BYTE_W-1:0]                data;
        logic [FLAGS_W-1:0]               flags;
        logic [OCC_OUT_W-1:0]             occ;
        logic [OCC_OUT_W-1:0]             peak;
        logic [CNT_NUM-1:0][CNT_W-1:0]    counters;
    } rx_result_t;

    // Shadow copy of the FIFO and its bookkeeping.
    logic [ENTRY_W-1:0]            shadow_entries [DEPTH];
    logic [PTR_W-1:0]              wr_ptr;
    logic [PTR_W-1:0]              rd_ptr;
    logic                          loss_armed;
    logic                          epoch_armed;
    logic                          overflow_run;
    logic [OCC_OUT_W-1:0]          peak_occ;
    logic [CNT_NUM-1:0][CNT_W-1:0] rx_stats;

    rx_result_t expected_results [$];

    task automatic predict_command(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word,
                                   output rx_result_t res);
        logic [PTR_W-1:0]   occ;
        logic [FLAGS_W-1:0] new_flags;
        logic [ENTRY_W-1:0] entry;
        occ = wr_ptr - rd_ptr;
        res.status = ST_DONE;
        res.data = '0;
        res.flags = '0;
        case (cmd)
            CMD_PUSH:
            begin
                rx_stats[CNT_OBSERVED] += 1;
                if (word[WB_OVERRUN]) rx_stats[CNT_OVERRUN] += 1;
                if (word[WB_FRAMING]) rx_stats[CNT_FRAMING] += 1;
                if (word[WB_PARITY]) rx_stats[CNT_PARITY] += 1;
                if (word[WB_BREAK]) rx_stats[CNT_BREAK] += 1;
                if (occ >= DEPTH)
                begin
                    rx_stats[CNT_DROPPED] += 1;
                    loss_armed = 1'b1;
                    // Only the first drop of a run opens a new episode.
                    if (!overflow_run)
                    begin
                        rx_stats[CNT_EPISODES] += 1;
                        overflow_run = 1'b1;
                    end
                    res.status = ST_DROPPED;
                end
                else
                begin
                    new_flags = {2'b00, word[WB_OVERRUN:WB_FRAMING]};
                    new_flags[FB_LOSS] = loss_armed;
                    new_flags[FB_EPOCH] = epoch_armed;
                    loss_armed = 1'b0;
                    epoch_armed = 1'b0;
                    overflow_run = 1'b0;
                    shadow_entries[wr_ptr[PTR_W-2:0]] = {new_flags, word[BYTE_W-1:0]};
                    wr_ptr = wr_ptr + 1'b1;
                end
            end
            CMD_POP:
            begin
                if (occ == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    if (occ > peak_occ) peak_occ = occ;
                    entry = shadow_entries[rd_ptr[PTR_W-2:0]];
                    res.data = entry[BYTE_W-1:0];
                    res.flags = entry[ENTRY_W-1:BYTE_W];
                    rd_ptr = rd_ptr + 1'b1;
                end
            end
            CMD_MARK:
            begin
                epoch_armed = 1'b1;
            end
            default:
            begin
                if (occ > peak_occ) peak_occ = occ;
                rd_ptr = wr_ptr;
            end
        endcase
        res.occ = occ;
        res.peak = peak_occ;
        res.counters = rx_stats;
    endtask

    task automatic check_field(input string field, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rx_result_t res;
        rx_result_t oldest;
        if (!rst_n)
        begin
            wr_ptr = '0;
            rd_ptr = '0;
            loss_armed = 1'b0;
            epoch_armed = 1'b0;
            overflow_run = 1'b0;
            peak_occ = '0;
            rx_stats = '0;
            expected_results.delete();
            pending_results = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result transfer, expected none, actual status %0d",
                             $time, status);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("status", oldest.status, status);
                    check_field("data_byte", oldest.data, data_byte);
                    check_field("entry_flags", oldest.flags, entry_flags);
                    check_field("occupancy_before", oldest.occ, occupancy_before);
                    check_field("high_water", oldest.peak, high_water);
                    check_field("overflow_episodes", oldest.counters[CNT_EPISODES],
                                overflow_episodes);
                    check_field("dropped_count", oldest.counters[CNT_DROPPED], dropped_count);
                    check_field("observed_count", oldest.counters[CNT_OBSERVED], observed_count);
                    check_field("overrun_count", oldest.counters[CNT_OVERRUN], overrun_count);
                    check_field("framing_count", oldest.counters[CNT_FRAMING], framing_count);
                    check_field("parity_count", oldest.counters[CNT_PARITY], parity_count);
                    check_field("break_count", oldest.counters[CNT_BREAK], break_count);
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_command(command, uart_word, res);
                expected_results.push_back(res);
            end
            pending_results = expected_results.size();
        end
    end

    initial
    begin
        fail_count = 0;
        pending_results = 0;
    end

endmodule

[test/uart_rx_fifo_with_loss_markers_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the UART receive FIFO: clock, reset, command stimulus and the verdict.
module uart_rx_fifo_with_loss_markers_tb;
    import urxf_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH;
    localparam int ITEM_TARGET = 1450;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [CMD_W-1:0]      command;
    logic [WORD_W-1:0]     uart_word;
    logic                  out_valid;
    logic                  out_stall;
    logic [STATUS_W-1:0]   status;
    logic [BYTE_W-1:0]     data_byte;
    logic [FLAGS_W-1:0]    entry_flags;
    logic [OCC_OUT_W-1:0]  occupancy_before;
    logic [OCC_OUT_W-1:0]  high_water;
    logic [CNT_W-1:0]      overflow_episodes;
    logic [CNT_W-1:0]      dropped_count;
    logic [CNT_W-1:0]      observed_count;
    logic [CNT_W-1:0]      overrun_count;
    logic [CNT_W-1:0]      framing_count;
    logic [CNT_W-1:0]      parity_count;
    logic [CNT_W-1:0]      break_count;
    int                    fail_count;
    int                    pending_results;

    int                    items_sent;
    bit                    quiet_stretch;
    bit                    rx_hold_req;
    int                    rx_hold_cycles;

    uart_rx_fifo_with_loss_markers dut (.*);

    urxf_result_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random stalls, quiet stretches, and a long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (rx_hold_cycles) @(negedge clk);
                out_stall <= 1'b0;
                rx_hold_req = 1'b0;
            end
            else if (quiet_stretch)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < 20);
            end
        end
    end

    // Offers one command and returns at the falling edge after its transfer.
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word);
        int gap;
        if (!quiet_stretch && $urandom_range(0, 99) < 15)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        uart_word <= word;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0) @(negedge clk);
    endtask

    function automatic logic [WORD_W-1:0] any_word();
        return WORD_W'($urandom_range(0, (1 << WORD_W) - 1));
    endfunction

    // Fills the FIFO past full, drains a little, overflows again, then drains partly.
    task automatic overflow_round();
        int fill;
        int taken;
        send_cmd(CMD_DISCARD, any_word());
        fill = DEPTH + $urandom_range(1, 6);
        for (int i = 0; i < fill; i++)
        begin
            if ($urandom_range(0, 99) < 4) send_cmd(CMD_MARK, any_word());
            send_cmd(CMD_PUSH, any_word());
        end
        taken = $urandom_range(1, 4);
        repeat (taken) send_cmd(CMD_POP, any_word());
        repeat (taken + $urandom_range(1, 3)) send_cmd(CMD_PUSH, any_word());
        send_cmd(CMD_MARK, any_word());
        repeat ($urandom_range(20, 60)) send_cmd(CMD_POP, any_word());
    endtask

    task automatic mixed_round(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45) send_cmd(CMD_PUSH, any_word());
            else if (pick < 85) send_cmd(CMD_POP, any_word());
            else if (pick < 93) send_cmd(CMD_MARK, any_word());
            else send_cmd(CMD_DISCARD, any_word());
        end
    endtask

    initial
    begin
        int round;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_PUSH;
        uart_word = '0;
        items_sent = 0;
        quiet_stretch = 1'b0;
        rx_hold_req = 1'b0;
        rx_hold_cycles = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty-FIFO cases, word extremes, each error bit alone, marks and discard.
        send_cmd(CMD_POP, 12'hFFF);
        send_cmd(CMD_DISCARD, 12'h000);
        send_cmd(CMD_PUSH, 12'h000);
        send_cmd(CMD_PUSH, 12'hFFF);
        send_cmd(CMD_MARK, 12'hABC);
        send_cmd(CMD_PUSH, 12'h1AA);
        send_cmd(CMD_PUSH, 12'h255);
        send_cmd(CMD_PUSH, 12'h400);
        send_cmd(CMD_PUSH, 12'h8FF);
        send_cmd(CMD_POP, 12'h000);
        send_cmd(CMD_POP, 12'h000);
        send_cmd(CMD_POP, 12'h000);
        send_cmd(CMD_MARK, 12'h000);
        send_cmd(CMD_MARK, 12'hFFF);
        send_cmd(CMD_PUSH, 12'h07F);
        send_cmd(CMD_DISCARD, 12'hFFF);
        send_cmd(CMD_POP, 12'h000);
        send_cmd(CMD_PUSH, 12'h0FF);
        send_cmd(CMD_POP, 12'h000);
        send_cmd(CMD_DISCARD, 12'h000);
        wait_all_results();

        round = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (round == 0)
            begin
                // The result side holds off while commands keep coming, so the block backs up.
                rx_hold_cycles = 120;
                rx_hold_req = 1'b1;
                overflow_round();
                wait_all_results();
            end
            else if (round == 1)
            begin
                quiet_stretch = 1'b1;
                mixed_round(60);
                quiet_stretch = 1'b0;
            end
            else if (round % 5 == 0)
            begin
                overflow_round();
                wait_all_results();
            end
            else
            begin
                mixed_round(40);
            end
            round++;
        end

        wait_all_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("uart_rx_fifo_with_loss_markers regression: pass");
        else
            $display("uart_rx_fifo_with_loss_markers regression: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("uart_rx_fifo_with_loss_markers regression: fail");
        $finish;
    end

endmodule
